@@ hdl/sbsh_pkg.sv @@
// shared types and constants for the sha-256 byte stream hasher
package sbsh_pkg;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_START = 6'd56;
   localparam logic [63:0] BLOCK_BITS = 64'd512;

   // where a schedule word comes from while loading the block
   typedef enum logic [1:0] {
      SRC_BUF  = 2'd0,
      SRC_PAD  = 2'd1,
      SRC_ZERO = 2'd2,
      SRC_LEN  = 2'd3
   } byte_src_type;

   typedef struct packed {
      logic         wr_byte;      // write req byte to buffer, bump fill
      logic         rd_en;        // issue buffer read
      logic [5:0]   rd_addr;
      logic         load_byte;    // shift a byte into the schedule word
      logic [5:0]   load_pos;     // byte position in padded block
      logic         pad_mode;     // padding block: pad rules apply
      logic         second_pad;   // second padding block: no data, no 0x80
      logic         start_round;  // copy chain to working vars, round 0
      logic         round_en;
      logic         finish;       // add working vars into chain
      logic         add_block;    // bit count += 512
      logic         reinit;       // back to initial values
      logic [2:0]   out_sel;
   } ctl_type;

   typedef struct packed {
      logic [5:0] fill;
   } sts_type;

   function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
      rotr = (v >> n) | (v << (32 - n));
   endfunction

endpackage

@@ hdl/sbsh_if.sv @@
// valid/ready channel interface
interface sbsh_if #(parameter int Width = 8);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hdl/sbsh_ram.sv @@
// generic simple dual port ram with registered read
module sbsh_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end
endmodule

@@ hdl/sbsh_datapath.sv @@
// buffer, message schedule, round unit and chaining value
module sbsh_datapath (
   input  logic             clock,
   input  logic             reset,
   input  sbsh_pkg::ctl_type ctl,
   input  logic [7:0]       req_byte,
   output sbsh_pkg::sts_type sts,
   output logic [31:0]      out_word
);
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [31:0] w_ff [16];
   logic [31:0] wload_ff;
   logic [5:0]  rnd_ff;
   logic [7:0]  rd_data;
   logic [7:0]  ld_byte;
   logic [63:0] total;
   logic [31:0] s0, s1, w_new, w_cur, t1, t2, e, a;

   sbsh_ram #(.Width(8), .Depth(64)) u_buf (
      .clock, .wr_en(ctl.wr_byte), .wr_addr(fill_ff), .wr_data(req_byte),
      .rd_en(ctl.rd_en), .rd_addr(ctl.rd_addr), .rd_data);

   assign total = bits_ff + {55'd0, fill_ff, 3'd0};

   // byte of the padded block at load_pos
   always_comb begin
      ld_byte = 8'd0;
      if (!ctl.pad_mode) begin
         ld_byte = rd_data;
      end else begin
         if (!ctl.second_pad && ctl.load_pos < fill_ff) ld_byte = rd_data;
         else if (!ctl.second_pad && ctl.load_pos == fill_ff) ld_byte = sbsh_pkg::PAD_BYTE;
         else if (ctl.load_pos >= sbsh_pkg::LEN_START &&
                  (ctl.second_pad || fill_ff < sbsh_pkg::LEN_START))
            ld_byte = total[8*(7-ctl.load_pos[2:0]) +: 8];
      end
   end

   assign s0 = sbsh_pkg::rotr(w_ff[1], 7) ^ sbsh_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = sbsh_pkg::rotr(w_ff[14], 17) ^ sbsh_pkg::rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign w_new = s1 + w_ff[9] + s0 + w_ff[0];
   assign w_cur = w_ff[0];
   assign e = v_ff[4];
   assign a = v_ff[0];
   assign t1 = v_ff[7] + (sbsh_pkg::rotr(e, 6) ^ sbsh_pkg::rotr(e, 11) ^ sbsh_pkg::rotr(e, 25))
             + ((e & v_ff[5]) ^ (~e & v_ff[6])) + sbsh_pkg::ROUND_K[rnd_ff] + w_cur;
   assign t2 = (sbsh_pkg::rotr(a, 2) ^ sbsh_pkg::rotr(a, 13) ^ sbsh_pkg::rotr(a, 22))
             + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));

   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (ctl.wr_byte) fill_in = fill_ff + 6'd1;
      if (ctl.add_block) bits_in = bits_ff + sbsh_pkg::BLOCK_BITS;
      if (ctl.reinit) begin
         fill_in = '0;
         bits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sbsh_pkg::INIT_H[i];
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         if (ctl.finish)
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
         else if (ctl.reinit)
            for (int i = 0; i < 8; i++) h_ff[i] <= sbsh_pkg::INIT_H[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_byte) begin
         wload_ff <= {wload_ff[23:0], ld_byte};
         if (ctl.load_pos[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= {wload_ff[23:0], ld_byte};
         end
      end
      if (ctl.start_round) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         rnd_ff <= '0;
      end else if (ctl.round_en) begin
         v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
         rnd_ff <= rnd_ff + 6'd1;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   assign sts.fill = fill_ff;
   assign out_word = h_ff[ctl.out_sel];
endmodule

@@ hdl/sbsh_ctrl.sv @@
// controller for byte intake, block loading, rounds and digest output
module sbsh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_has_byte,
   input  logic              req_end,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_index,
   output sbsh_pkg::ctl_type ctl,
   input  sbsh_pkg::sts_type sts
);
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LOAD  = 6'b000010,
      ST_ROUND = 6'b000100,
      ST_FIN   = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_NEXT  = 6'b100000
   } state_type;

   state_type  state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;      // load: read issue count 0..64
   logic       pad_ff, pad_in;      // working on padding
   logic       sec_ff, sec_in;      // second padding block
   logic       endp_ff, endp_in;    // message end pending after full block
   logic [2:0] oidx_ff, oidx_in;
   logic       acc;

   assign req_ready = (state_ff == ST_IDLE);
   assign acc = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_index = oidx_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pad_in = pad_ff;
      sec_in = sec_ff;
      endp_in = endp_ff;
      oidx_in = oidx_ff;
      ctl = '0;
      ctl.pad_mode = pad_ff;
      ctl.second_pad = sec_ff;
      ctl.out_sel = oidx_ff;
      ctl.rd_addr = cnt_ff[5:0];
      ctl.load_pos = cnt_ff[5:0] - 6'd1;
      case (state_ff)
         ST_IDLE: begin
            if (acc) begin
               ctl.wr_byte = req_has_byte;
               cnt_in = '0;
               sec_in = 1'b0;
               if (req_has_byte && sts.fill == 6'd63) begin
                  pad_in = 1'b0;
                  endp_in = req_end;
                  state_in = ST_LOAD;
               end else if (req_end) begin
                  pad_in = 1'b1;
                  endp_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_LOAD: begin
            // read issued at cnt, data loaded in the cycle after
            ctl.rd_en = cnt_ff < 7'd64;
            ctl.load_byte = cnt_ff != 7'd0;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd64) begin
               ctl.start_round = 1'b1;
               cnt_in = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            ctl.round_en = 1'b1;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ST_FIN;
         end
         ST_FIN: begin
            ctl.finish = 1'b1;
            cnt_in = '0;
            if (!pad_ff) begin
               ctl.add_block = 1'b1;
               // full block: fill wrapped to zero on the byte write
               if (endp_ff) begin
                  pad_in = 1'b1;
                  endp_in = 1'b0;
                  state_in = ST_LOAD;
               end else state_in = ST_IDLE;
            end else if (!sec_ff && sts.fill >= sbsh_pkg::LEN_START) begin
               sec_in = 1'b1;
               state_in = ST_LOAD;
            end else begin
               oidx_in = '0;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            ctl.reinit = 1'b1;
            pad_in = 1'b0;
            sec_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         pad_ff <= 1'b0;
         sec_ff <= 1'b0;
         endp_ff <= 1'b0;
         oidx_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
         sec_ff <= sec_in;
         endp_ff <= endp_in;
         oidx_ff <= oidx_in;
      end
   end
endmodule

@@ hdl/sha256_byte_stream_hasher.sv @@
// top level of the streaming sha-256 byte hasher
// a byte that does not complete a block is taken while the controller stays idle
// a full block is then loaded byte by byte, run through 64 rounds and added into the chain
// end of message adds one or two padding blocks, 8 digest beats and a restart state
// no new byte is taken while a block is loaded and run through the rounds
// synchronous reset restores the initial hash values and clears the counts
module sha256_byte_stream_hasher (
   input  logic  clock,
   input  logic  reset,
   sbsh_if.sink   req,
   sbsh_if.source rsp
);
   sbsh_pkg::ctl_type ctl;
   sbsh_pkg::sts_type sts;
   logic [31:0] word;
   logic [2:0]  idx;

   sbsh_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_has_byte(req.data[8]), .req_end(req.data[9]),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .rsp_index(idx), .ctl, .sts);

   sbsh_datapath u_dp (
      .clock, .reset, .ctl, .req_byte(req.data[7:0]), .sts, .out_word(word));

   // payload: {last_word, word_index, digest_word}
   assign rsp.data = {idx == 3'd7, idx, word};

`ifndef SYNTHESIS
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("input taken while digest out");
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data[35]) |-> rsp.data[34:32] == 3'd7)
      else $error("last flag off word 7");
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.ready && rsp.data[35]) |=> !rsp.valid)
      else $error("digest beats continue past last");
`endif
endmodule

@@ tb/tb_top.sv @@
// testbench for the streaming sha-256 hasher: directed and random messages checked against a local predictor
`timescale 1ns / 1ps

module tb_top;

   typedef struct packed {
      logic       end_of_message;
      logic       has_byte;
      logic [7:0] data_byte;
   } msg_beat_type;

   typedef struct packed {
      logic        last_word;
      logic [2:0]  word_index;
      logic [31:0] digest_word;
   } digest_beat_type;

   typedef struct {
      msg_beat_type beat;
      bit           drain_first;
   } pending_type;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sbsh_if #(.Width($bits(msg_beat_type))) req ();
   sbsh_if #(.Width($bits(digest_beat_type))) rsp ();

   sha256_byte_stream_hasher dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  block_bytes [64];
   logic [5:0]  bytes_held;
   logic [63:0] done_bits;

   pending_type     msg_queue [$];
   digest_beat_type digest_queue [$];
   int error_count = 0;
   int cycle_count = 0;

   task automatic report(input string what);
      error_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic logic [31:0] ror(input logic [31:0] v, input int n);
      return (v >> n) | (v << (32 - n));
   endfunction

   task automatic sha_compress(input logic [7:0] blk [64]);
      logic [31:0] w [64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 64; i++)
         w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
                (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int i = 0; i < 64; i++) begin
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g)) +
              sbsh_pkg::ROUND_K[i] + w[i];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic restart_message();
      for (int i = 0; i < 8; i++)
         hash_state[i] = sbsh_pkg::INIT_H[i];
      bytes_held = '0;
      done_bits = '0;
   endtask

   task automatic hash_beat(input msg_beat_type m);
      logic [7:0]  pad [64];
      logic [63:0] total;
      digest_beat_type d;
      int n;
      if (m.has_byte) begin
         block_bytes[bytes_held] = m.data_byte;
         if (bytes_held == 6'd63) begin
            sha_compress(block_bytes);
            done_bits += 64'd512;
         end
         bytes_held = bytes_held + 6'd1;
      end
      if (!m.end_of_message)
         return;
      n = bytes_held;
      for (int i = 0; i < 64; i++)
         pad[i] = (i < n) ? block_bytes[i] : 8'h00;
      pad[n] = 8'h80;
      // no room for the length: pad spills into a second block
      if (n >= 56) begin
         sha_compress(pad);
         for (int i = 0; i < 64; i++)
            pad[i] = 8'h00;
      end
      total = done_bits + 64'(n) * 8;
      for (int i = 0; i < 8; i++)
         pad[63-i] = total[8*i +: 8];
      sha_compress(pad);
      for (int i = 0; i < 8; i++) begin
         d.digest_word = hash_state[i];
         d.word_index = 3'(i);
         d.last_word = (i == 7);
         digest_queue.push_back(d);
      end
      restart_message();
   endtask

   task automatic queue_beat(input logic [7:0] b, input bit has, input bit eom,
                             input bit drain);
      pending_type p;
      p.beat.data_byte = b;
      p.beat.has_byte = has;
      p.beat.end_of_message = eom;
      p.drain_first = drain;
      msg_queue.push_back(p);
   endtask

   // message of len bytes; the end flag rides on the last byte or on an empty beat
   task automatic queue_message(input int len, input bit drain);
      bit on_byte;
      on_byte = (len > 0) && ($urandom_range(1, 0) == 1);
      for (int i = 0; i < len; i++) begin
         queue_beat(8'($urandom), 1'b1, on_byte && (i == len - 1), drain && (i == 0));
         if ($urandom_range(15, 0) == 0)
            queue_beat(8'($urandom), 1'b0, 1'b0, 1'b0);
      end
      if (!on_byte)
         queue_beat(8'($urandom), 1'b0, 1'b1, drain && (len == 0));
   endtask

   // sender: bursts with random gaps
   int gap_left = 0;
   int burst_left = 4;
   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         restart_message();
      end else begin
         if (req.valid && req.ready)
            hash_beat(msg_beat_type'(req.data));
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (msg_queue.size() > 0 &&
                         !(msg_queue[0].drain_first && digest_queue.size() > 0)) begin
               req.data <= msg_queue[0].beat;
               req.valid <= 1'b1;
               void'(msg_queue.pop_front());
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(40, 1);
                  gap_left = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 0);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // receiver: stall pattern changes mode every so often
   int stall_mode = 0;
   int mode_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (digest_queue.size() == 0) begin
               report($sformatf("unexpected digest beat %h", rsp.data));
            end else begin
               digest_beat_type got, want;
               got = digest_beat_type'(rsp.data);
               want = digest_queue.pop_front();
               if (got.digest_word !== want.digest_word)
                  report($sformatf("digest_word %h, want %h", got.digest_word,
                                   want.digest_word));
               if (got.word_index !== want.word_index)
                  report($sformatf("word_index %0d, want %0d", got.word_index,
                                   want.word_index));
               if (got.last_word !== want.last_word)
                  report($sformatf("last_word %b, want %b", got.last_word,
                                   want.last_word));
            end
         end
         if (mode_left <= 0) begin
            stall_mode = $urandom_range(3, 0);
            mode_left = $urandom_range(60, 5);
         end
         mode_left--;
         case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(1, 0) == 1);
            2: rsp.ready <= (cycle_count % 5 == 0);
            default: rsp.ready <= ($urandom_range(30, 0) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int items;
      int len;
      // directed: empty message, idle beat, "abc", extreme bytes, end on empty beat
      queue_beat(8'h00, 1'b0, 1'b1, 1'b0);
      queue_beat(8'hff, 1'b0, 1'b0, 1'b0);
      queue_beat(8'h61, 1'b1, 1'b0, 1'b0);
      queue_beat(8'h62, 1'b1, 1'b0, 1'b0);
      queue_beat(8'h63, 1'b1, 1'b1, 1'b0);
      queue_beat(8'h00, 1'b1, 1'b0, 1'b1);
      queue_beat(8'hff, 1'b1, 1'b0, 1'b0);
      queue_beat(8'haa, 1'b0, 1'b1, 1'b0);
      queue_beat(8'h55, 1'b1, 1'b1, 1'b0);
      // padding edges: length spills, exact block or block completed on the end beat
      queue_message(56, 1'b1);
      queue_message(64, 1'b0);
      items = 9 + 57 + 65;
      while (items < 150) begin
         len = ($urandom_range(4, 0) == 0) ? $urandom_range(70, 50) : $urandom_range(12, 0);
         queue_message(len, $urandom_range(9, 0) == 0);
         items += len + 1;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (msg_queue.size() == 0);
      @(posedge clock);
      while (req.valid || digest_queue.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && digest_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
